// ----- rtl/core/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants of the block ring buffer
// Sizes, command and status codes, and the item and control structs that
// pass between the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int BLOCK_MAX = 64;
  localparam int SLOTS_MAX = 16;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 7;   // holds 0..BLOCK_MAX
  localparam int CNT_W    = 5;   // holds 0..SLOTS_MAX
  localparam int IDX_W    = $clog2(BLOCK_MAX);
  localparam int SLOT_W   = $clog2(SLOTS_MAX);
  localparam int ADDR_W   = SLOT_W + IDX_W;
  localparam int DEPTH    = SLOTS_MAX * BLOCK_MAX;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_SLOTS    = 2'd1
  } reg_idx_t;

  // Which kind of result the datapath builds this cycle.
  typedef enum logic [1:0] {
    EMIT_APPEND,
    EMIT_COMMIT,
    EMIT_EMPTY,
    EMIT_SAMPLE
  } emit_kind_t;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       last;
    logic [1:0]                 status;
    logic [LEN_W-1:0]           block_len;
    logic [CNT_W-1:0]           slots_free;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic       wr_sample;
    logic       commit;
    logic       rd_start;
    logic       rd_issue;
    logic       emit;
    emit_kind_t emit_kind;
    status_t    emit_status;
  } brb_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic at_cap;
    logic ring_empty;
    logic head_len_zero;
    logic rd_last;
  } brb_sts_t;

endpackage

// ----- rtl/core/block_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// block_ring_buffer: ring of sample blocks with a per-slot length table
// Top level: joins the command sequencer and the datapath.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. Each
// result is shown for exactly one cycle with out_valid high, starting the
// cycle after the edge that produced it; the receiver cannot stall, so it
// must take every strobe as it comes. Append, commit and a read that finds
// an empty ring or an empty block give one result and leave busy low, so
// these items can follow each other every cycle. A read of a block of n
// samples holds busy high while the sequencer is in its read state, so the
// next item waits: the samples come one per cycle out of the single read
// port of the sample store, the first one once the read port has registered
// it, and the last one marked. Every result carries the free slot count after
// its item. A write to either configuration register also empties the
// ring; write registers only while no read is in progress. The sample store
// and length table need no clearing after reset.
module block_ring_buffer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  brb_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output brb_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [brb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import brb_pkg::*;

  brb_ctl_t ctl;   // commands from the sequencer
  brb_sts_t sts;   // ring status back to it

  // Decode items and sequence block reads.
  brb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_data.cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Hold the ring, store samples and register results.
  brb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (in_data.sample),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/brb_ctrl.sv -----
// ----------------------------------------------------------------------------
// brb_ctrl: command sequencer of the block ring buffer
// Decodes accepted items, picks the result status and steps the datapath
// through the sample reads of a block.
// ----------------------------------------------------------------------------
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        cmd,
  input  brb_pkg::brb_sts_t sts,
  output brb_pkg::brb_ctl_t ctl,
  output logic              busy
);
  import brb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt       = state_r;
    ctl             = '0;
    ctl.emit_kind   = EMIT_APPEND;
    ctl.emit_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_APPEND: begin
              ctl.emit      = 1'b1;
              ctl.emit_kind = EMIT_APPEND;
              if (sts.full) begin
                ctl.emit_status = ST_FULL;
              end else if (sts.at_cap) begin
                ctl.emit_status = ST_OVERFLOW;
              end else begin
                ctl.wr_sample = 1'b1;
              end
            end
            CMD_COMMIT: begin
              ctl.emit      = 1'b1;
              ctl.emit_kind = EMIT_COMMIT;
              if (sts.full) begin
                ctl.emit_status = ST_FULL;
              end else begin
                ctl.commit = 1'b1;
              end
            end
            CMD_READ: begin
              if (sts.ring_empty) begin
                ctl.emit        = 1'b1;
                ctl.emit_kind   = EMIT_EMPTY;
                ctl.emit_status = ST_EMPTY;
              end else begin
                ctl.rd_start = 1'b1;
                if (sts.head_len_zero) begin
                  ctl.emit      = 1'b1;
                  ctl.emit_kind = EMIT_EMPTY;
                end else begin
                  state_nxt = S_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        ctl.rd_issue  = 1'b1;
        ctl.emit      = 1'b1;
        ctl.emit_kind = EMIT_SAMPLE;
        if (sts.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt == S_READ);
    end
  end

  assign busy = busy_r;

endmodule

// ----- rtl/core/brb_dp.sv -----
// ----------------------------------------------------------------------------
// brb_dp: datapath of the block ring buffer
// Holds the configuration, the ring pointers, the length table and the
// sample store, and registers each result item.
// ----------------------------------------------------------------------------
module brb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [brb_pkg::SAMPLE_W-1:0] sample,
  input  brb_pkg::brb_ctl_t             ctl,
  output brb_pkg::brb_sts_t             sts,
  output logic                          out_valid,
  output brb_pkg::out_item_t            out_data
);
  import brb_pkg::*;

  logic [LEN_W-1:0]    cap_r;
  logic [CNT_W-1:0]    slots_r;
  logic [SLOT_W-1:0]   read_slot_r, read_slot_nxt;
  logic [SLOT_W-1:0]   write_slot_r, write_slot_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [LEN_W-1:0]    open_len_r, open_len_nxt;

  logic [LEN_W-1:0]    len_tab [SLOTS_MAX];
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] mem_q_r;

  logic [SLOT_W-1:0]   rd_slot_r;
  logic [LEN_W-1:0]    rd_len_r;
  logic [IDX_W-1:0]    rd_idx_r;

  logic                out_valid_r;
  logic                out_smp_r;
  logic                out_last_r, out_last_nxt;
  logic [1:0]          out_status_r;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [CNT_W-1:0]    out_free_r;

  logic                cfg_hit;
  logic [LEN_W-1:0]    cap_wr;
  logic [CNT_W-1:0]    slots_wr;
  logic [CNT_W-1:0]    ws_inc, rs_inc;

  always_comb begin
    sts.full          = (used_r >= slots_r);
    sts.at_cap        = (open_len_r >= cap_r);
    sts.ring_empty    = (used_r == '0);
    sts.head_len_zero = (len_tab[read_slot_r] == '0);
    sts.rd_last       = ({1'b0, rd_idx_r} == (rd_len_r - LEN_W'(1)));

    ws_inc         = {1'b0, write_slot_r} + CNT_W'(1);
    rs_inc         = {1'b0, read_slot_r} + CNT_W'(1);
    write_slot_nxt = (ws_inc >= slots_r) ? '0 : ws_inc[SLOT_W-1:0];
    read_slot_nxt  = (rs_inc >= slots_r) ? '0 : rs_inc[SLOT_W-1:0];

    used_nxt = used_r;
    if (ctl.commit) begin
      used_nxt = used_r + CNT_W'(1);
    end else if (ctl.rd_start) begin
      used_nxt = used_r - CNT_W'(1);
    end

    open_len_nxt = open_len_r;
    if (ctl.wr_sample) begin
      open_len_nxt = open_len_r + LEN_W'(1);
    end else if (ctl.commit) begin
      open_len_nxt = '0;
    end

    // Clamp register values into their legal range on write.
    if (cfg_data == '0) begin
      cap_wr = LEN_W'(1);
    end else if (cfg_data > LEN_W'(BLOCK_MAX)) begin
      cap_wr = LEN_W'(BLOCK_MAX);
    end else begin
      cap_wr = cfg_data;
    end
    if (cfg_data[CNT_W-1:0] == '0) begin
      slots_wr = CNT_W'(1);
    end else if (cfg_data[CNT_W-1:0] > CNT_W'(SLOTS_MAX)) begin
      slots_wr = CNT_W'(SLOTS_MAX);
    end else begin
      slots_wr = cfg_data[CNT_W-1:0];
    end

    cfg_hit = cfg_we && ((cfg_index == REG_CAPACITY) || (cfg_index == REG_SLOTS));

    out_last_nxt = 1'b1;
    out_len_nxt  = '0;
    case (ctl.emit_kind)
      EMIT_APPEND: out_len_nxt = open_len_nxt;
      EMIT_COMMIT: out_len_nxt = open_len_r;
      EMIT_EMPTY:  out_len_nxt = '0;
      EMIT_SAMPLE: begin
        out_len_nxt  = rd_len_r;
        out_last_nxt = sts.rd_last;
      end
      default:     out_len_nxt = '0;
    endcase
  end

  // Control state: configuration, ring pointers, result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= LEN_W'(BLOCK_MAX);
      slots_r      <= CNT_W'(SLOTS_MAX);
      read_slot_r  <= '0;
      write_slot_r <= '0;
      used_r       <= '0;
      open_len_r   <= '0;
      out_valid_r  <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_CAPACITY) begin
        cap_r <= cap_wr;
      end else begin
        slots_r <= slots_wr;
      end
      read_slot_r  <= '0;
      write_slot_r <= '0;
      used_r       <= '0;
      open_len_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.commit) begin
        write_slot_r <= write_slot_nxt;
      end
      if (ctl.rd_start) begin
        read_slot_r <= read_slot_nxt;
      end
      used_r      <= used_nxt;
      open_len_r  <= open_len_nxt;
      out_valid_r <= ctl.emit;
    end
  end

  // Sample store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_sample) begin
      mem[{write_slot_r, open_len_r[IDX_W-1:0]}] <= sample;
    end
    if (ctl.rd_issue) begin
      mem_q_r <= mem[{rd_slot_r, rd_idx_r}];
    end
  end

  // Length table, read cursor and result payload.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      len_tab[write_slot_r] <= open_len_r;
    end
    if (ctl.rd_start) begin
      rd_slot_r <= read_slot_r;
      rd_len_r  <= len_tab[read_slot_r];
      rd_idx_r  <= '0;
    end else if (ctl.rd_issue) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
    if (ctl.emit) begin
      out_smp_r    <= (ctl.emit_kind == EMIT_SAMPLE);
      out_last_r   <= out_last_nxt;
      out_status_r <= ctl.emit_status;
      out_len_r    <= out_len_nxt;
      out_free_r   <= slots_r - used_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.out_sample = out_smp_r ? mem_q_r : '0;
  assign out_data.last       = out_last_r;
  assign out_data.status     = out_status_r;
  assign out_data.block_len  = out_len_r;
  assign out_data.slots_free = out_free_r;

endmodule

// ----- verif/block_ring_buffer_test.sv -----
// ----------------------------------------------------------------------------
// block_ring_buffer_test: self-checking testbench of the block ring buffer
// Drives append, commit and read items through the start/busy handshake,
// predicts every result from a local copy of the ring state, and compares
// each strobed result field by field with the oldest pending prediction.
// Runs a directed pass over the corner cases, then random block traffic
// under several capacity and slot count settings, clamped values included.
// ----------------------------------------------------------------------------
module block_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brb_pkg::*;

  // Command 3 has no meaning in the block; it must be ignored.
  localparam logic [1:0] CMD_NONE = 2'd3;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_LIMIT  = 5000;
  // A command 3 item leaves nothing to wait for; give the block time to settle.
  localparam int SETTLE_CYCLES = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  block_ring_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Local copy of the ring state
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] sample_mem [SLOTS_MAX][BLOCK_MAX];
  logic [LEN_W-1:0]    block_len_tab [SLOTS_MAX];
  int                  rd_slot;
  int                  wr_slot;
  int                  ring_used;
  int                  open_len;
  logic [LEN_W-1:0]    capacity_reg;
  logic [CNT_W-1:0]    slot_count_reg;

  out_item_t awaited_results[$];
  int        error_count;
  int        cycle_count;
  int        burst_left;
  bit        sender_gaps_on;

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[block_ring_buffer] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Capacity and slot count as the block applies them: zero acts as one,
  // anything above the maximum acts as the maximum.
  function automatic int capacity_now();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > BLOCK_MAX) return BLOCK_MAX;
    return int'(capacity_reg);
  endfunction

  function automatic int slots_now();
    if (slot_count_reg == 0) return 1;
    if (slot_count_reg > SLOTS_MAX) return SLOTS_MAX;
    return int'(slot_count_reg);
  endfunction

  function automatic int advance_slot(int s);
    return (s + 1 >= slots_now()) ? 0 : s + 1;
  endfunction

  function automatic void clear_ring();
    rd_slot   = 0;
    wr_slot   = 0;
    ring_used = 0;
    open_len  = 0;
  endfunction

  // Work out every result one accepted item causes and queue them in order.
  task automatic compute_ring_results(in_item_t it);
    out_item_t r;
    int        n_slots;
    int        rs;
    int        len;
    bit        full;
    n_slots = slots_now();
    full    = (ring_used >= n_slots);
    r       = '0;
    r.last  = 1'b1;
    case (it.cmd)
      CMD_APPEND: begin
        if (full) begin
          r.status = ST_FULL;
        end else if (open_len >= capacity_now()) begin
          r.status = ST_OVERFLOW;
        end else begin
          sample_mem[wr_slot][open_len] = it.sample;
          open_len++;
          r.status = ST_OK;
        end
        r.block_len  = LEN_W'(open_len);
        r.slots_free = CNT_W'(n_slots - ring_used);
        awaited_results.push_back(r);
      end
      CMD_COMMIT: begin
        r.block_len = LEN_W'(open_len);
        if (full) begin
          // Refused: the open block stays as it is.
          r.status = ST_FULL;
        end else begin
          block_len_tab[wr_slot] = LEN_W'(open_len);
          wr_slot  = advance_slot(wr_slot);
          ring_used++;
          open_len = 0;
          r.status = ST_OK;
        end
        r.slots_free = CNT_W'(n_slots - ring_used);
        awaited_results.push_back(r);
      end
      CMD_READ: begin
        if (ring_used == 0) begin
          r.status     = ST_EMPTY;
          r.slots_free = CNT_W'(n_slots);
          awaited_results.push_back(r);
        end else begin
          rs      = rd_slot;
          len     = int'(block_len_tab[rs]);
          rd_slot = advance_slot(rd_slot);
          ring_used--;
          r.status     = ST_OK;
          r.slots_free = CNT_W'(n_slots - ring_used);
          if (len == 0) begin
            // An empty block still frees its slot with one result.
            awaited_results.push_back(r);
          end else begin
            for (int i = 0; i < len; i++) begin
              r.out_sample = sample_mem[rs][i];
              r.last       = (i == len - 1);
              r.block_len  = LEN_W'(len);
              awaited_results.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of items with random gaps, noise on the bus while idle
  // --------------------------------------------------------------------------
  task automatic pace_sender();
    int       gap;
    in_item_t noise;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        noise.cmd    = 2'($urandom_range(0, 3));
        noise.sample = SAMPLE_W'($urandom);
        start   <= 1'b0;
        in_data <= noise;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offer one item and hold it until the block takes it. Returns at the
  // accept edge with start still high, so a following item goes back to back.
  task automatic send_item(logic [1:0] cmd, logic [SAMPLE_W-1:0] smp);
    in_item_t it;
    it.cmd    = cmd;
    it.sample = smp;
    pace_sender();
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    compute_ring_results(it);
  endtask

  // Hold the sender until every pending result has come out.
  task automatic wait_drained();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; any write to a real register also empties the ring.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_CAPACITY) begin
      capacity_reg = val;
      clear_ring();
    end else if (idx == REG_SLOTS) begin
      slot_count_reg = val[CNT_W-1:0];
      clear_ring();
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ring(logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] slots);
    wait_drained();
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_SLOTS, slots);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every strobe is taken; compare with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n === 1'b1) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid unknown", 32'(out_valid), 32'd0);
      end else if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_data), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.out_sample !== want.out_sample)
            report_mismatch("out_sample", 32'(out_data.out_sample), 32'(want.out_sample));
          if (out_data.last !== want.last)
            report_mismatch("last", 32'(out_data.last), 32'(want.last));
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.block_len !== want.block_len)
            report_mismatch("block_len", 32'(out_data.block_len), 32'(want.block_len));
          if (out_data.slots_free !== want.slots_free)
            report_mismatch("slots_free", 32'(out_data.slots_free), 32'(want.slots_free));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases at reset settings and at tiny rings.
  task automatic test_directed();
    sender_gaps_on = 1'b0;
    // Reset settings: capacity 64, 16 slots. Read an empty ring first.
    send_item(CMD_READ, '0);
    // Sample extremes and alternating bit patterns.
    send_item(CMD_APPEND, 16'h8000);
    send_item(CMD_APPEND, 16'h7fff);
    send_item(CMD_APPEND, 16'h0000);
    send_item(CMD_APPEND, 16'hffff);
    send_item(CMD_APPEND, 16'h5555);
    send_item(CMD_APPEND, 16'haaaa);
    send_item(CMD_COMMIT, '0);
    send_item(CMD_NONE, 16'hffff);
    send_item(CMD_READ, '0);

    // Two slots of two samples: overflow, empty block, full ring.
    set_ring(7'd2, 7'd2);
    send_item(CMD_APPEND, 16'h1234);
    send_item(CMD_APPEND, 16'hfedc);
    send_item(CMD_APPEND, 16'h4321);   // past capacity: dropped
    send_item(CMD_COMMIT, '0);
    send_item(CMD_COMMIT, '0);         // empty block, ring now full
    send_item(CMD_APPEND, 16'h0f0f);   // full: refused
    send_item(CMD_COMMIT, '0);         // full: refused
    send_item(CMD_READ, '0);
    send_item(CMD_READ, '0);           // empty block frees its slot
    send_item(CMD_READ, '0);           // ring empty again

    // Zero in both registers acts as one.
    set_ring(7'd0, 7'd0);
    send_item(CMD_APPEND, 16'h8001);
    send_item(CMD_APPEND, 16'h7ffe);
    send_item(CMD_COMMIT, '0);
    send_item(CMD_COMMIT, '0);
    send_item(CMD_READ, '0);
  endtask

  // Writes to missing register indexes change nothing, the ring included.
  task automatic test_spare_registers();
    set_ring(7'd4, 7'd3);
    send_item(CMD_APPEND, 16'h0001);
    send_item(CMD_COMMIT, '0);
    send_item(CMD_APPEND, 16'h0002);
    wait_drained();
    write_reg(REG_SPARE_2, 7'h7f);
    write_reg(REG_SPARE_3, 7'h55);
    send_item(CMD_COMMIT, '0);
    send_item(CMD_READ, '0);
    send_item(CMD_READ, '0);
  endtask

  // Random traffic: mostly whole blocks with random content, plus reads and
  // a little noise. Block lengths lean small, with full and overlong blocks.
  task automatic test_random_traffic(logic [CFG_DATA_W-1:0] cap,
                                     logic [CFG_DATA_W-1:0] slots, int n_items);
    int sent;
    int pick;
    int len;
    logic [1:0] cmd;
    set_ring(cap, slots);
    sender_gaps_on = ($urandom_range(0, 3) != 0);
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        case ($urandom_range(0, 7))
          0:       len = 0;
          1:       len = capacity_now() + $urandom_range(1, 2);
          2:       len = capacity_now();
          default: len = $urandom_range(1, (capacity_now() < 6) ? capacity_now() : 6);
        endcase
        repeat (len) send_item(CMD_APPEND, SAMPLE_W'($urandom));
        send_item(CMD_COMMIT, SAMPLE_W'($urandom));
        sent += len + 1;
      end else if (pick < 9) begin
        send_item(CMD_READ, SAMPLE_W'($urandom));
        sent++;
      end else begin
        cmd = 2'($urandom_range(0, 3));
        send_item(cmd, SAMPLE_W'($urandom));
        if (cmd != CMD_NONE) sent++;
      end
      // Now and then hold off until the block has said everything.
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    error_count    = 0;
    cycle_count    = 0;
    burst_left     = 0;
    sender_gaps_on = 1'b1;
    capacity_reg   = LEN_W'(BLOCK_MAX);
    slot_count_reg = CNT_W'(SLOTS_MAX);
    clear_ring();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_spare_registers();
    test_random_traffic(7'd64, 7'd16, 80);
    test_random_traffic(7'd1, 7'd1, 30);
    test_random_traffic(7'd127, 7'd31, 40);   // clamp to the maxima
    test_random_traffic(7'd0, 7'd0, 20);      // clamp to one
    test_random_traffic(7'd3, 7'd4, 60);
    repeat (3) begin
      test_random_traffic(7'($urandom_range(0, 127)), 7'($urandom_range(0, 31)), 40);
    end
    test_random_traffic(7'd64, 7'd2, 60);
    test_random_traffic(7'd2, 7'd16, 40);

    // Drop start and wait for the last results, then a little longer.
    start  <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never came", 32'(awaited_results.size()), 32'd0);

    if (error_count == 0) begin
      $display("[block_ring_buffer] OK");
    end else begin
      $display("[block_ring_buffer] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/brb_pkg.sv
rtl/core/brb_ctrl.sv
rtl/core/brb_dp.sv
rtl/core/block_ring_buffer.sv
verif/block_ring_buffer_test.sv
